>>> src/dtws_pkg.sv
// shared constants, request codes, state encoding and memory command structs
// for the dirty tile work stack; no dependencies
package dtws_pkg;

  localparam int MAX_TILES  = 4096;
  localparam int TILE_W     = $clog2(MAX_TILES);
  localparam int COUNT_W    = TILE_W + 1;
  localparam int DIM_W      = 7;
  localparam int WORD_W     = 64;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int ROWS       = MAX_TILES / WORD_W;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int DIV_STEP_W = $clog2(TILE_W);

  typedef enum logic [1:0] {
    REQ_MARK_ONE = 2'd0,
    REQ_MARK_NBR = 2'd1,
    REQ_MARK_ALL = 2'd2,
    REQ_TAKE     = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MARK_RD,
    S_MARK_WR,
    S_NBR,
    S_FILL,
    S_POP_LOOKUP,
    S_POP_CLEAR,
    S_DONE
  } state_t;

  // bitmap port: lookup a tile, then set or clear the bit that was looked up,
  // or fill one whole row against a tile count
  typedef struct packed {
    logic               lookup;
    logic               set;
    logic               clr;
    logic               fill;
    logic [TILE_W-1:0]  tile;
    logic [ROW_W-1:0]   row;
    logic [COUNT_W-1:0] count;
  } bmp_cmd_t;

  typedef struct packed {
    logic               rd;
    logic               wr;
    logic               fill;
    logic [TILE_W-1:0]  addr;
    logic [TILE_W-1:0]  wdata;
    logic [COUNT_W-1:0] count;
  } stk_cmd_t;

endpackage

>>> src/dtws_bitmap.sv
// pending-bit memory, one row of WORD_W tile bits per address, with
// read-modify-write of single bits and whole-row fills; uses dtws_pkg
module dtws_bitmap import dtws_pkg::*; (
  input  logic     clk,
  input  bmp_cmd_t cmd,
  output logic     pending
);

  logic [WORD_W-1:0]  mem [ROWS];
  logic [WORD_W-1:0]  word_q;
  logic [ROW_W-1:0]   row_q;
  logic [BIT_W-1:0]   bit_q;
  logic [WORD_W-1:0]  bit_mask;
  logic [WORD_W-1:0]  fill_word;
  logic [WORD_W-1:0]  wr_word;
  logic [ROW_W-1:0]   wr_row;
  logic               wr_en;
  logic [COUNT_W-1:0] row_base;
  logic [COUNT_W-1:0] row_span;

  assign row_base = COUNT_W'(cmd.row) << BIT_W;
  assign row_span = cmd.count - row_base;

  // bits of this row below the tile count are set, the rest cleared
  always_comb begin
    if (cmd.count >= row_base + COUNT_W'(WORD_W)) begin
      fill_word = '1;
    end else if (cmd.count <= row_base) begin
      fill_word = '0;
    end else begin
      fill_word = ~({WORD_W{1'b1}} << row_span[BIT_W-1:0]);
    end
  end

  assign bit_mask = WORD_W'(1) << bit_q;
  assign wr_en    = cmd.set | cmd.clr | cmd.fill;
  assign wr_row   = cmd.fill ? cmd.row : row_q;

  always_comb begin
    if (cmd.fill) begin
      wr_word = fill_word;
    end else if (cmd.set) begin
      wr_word = word_q | bit_mask;
    end else begin
      wr_word = word_q & ~bit_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      word_q <= mem[cmd.tile[TILE_W-1:BIT_W]];
      row_q  <= cmd.tile[TILE_W-1:BIT_W];
      bit_q  <= cmd.tile[BIT_W-1:0];
    end
    if (wr_en) begin
      mem[wr_row] <= wr_word;
    end
  end

  assign pending = word_q[bit_q];

endmodule

>>> src/dtws_stack.sv
// work stack memory with a watermark below which entries still hold the
// identity fill of the last mark-all; uses dtws_pkg
module dtws_stack import dtws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  stk_cmd_t          cmd,
  output logic [TILE_W-1:0] rd_data
);

  logic [TILE_W-1:0]  mem [MAX_TILES];
  logic [TILE_W-1:0]  mem_q;
  logic [TILE_W-1:0]  addr_q;
  logic               ident_q;
  logic [COUNT_W-1:0] ident_lim;

  // positions below ident_lim were not written since the fill, so hold their own index
  always_ff @(posedge clk) begin
    if (rst) begin
      ident_lim <= '0;
    end else if (cmd.fill) begin
      ident_lim <= cmd.count;
    end else if (cmd.wr && (COUNT_W'(cmd.addr) < ident_lim)) begin
      ident_lim <= COUNT_W'(cmd.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    if (cmd.rd) begin
      mem_q   <= mem[cmd.addr];
      addr_q  <= cmd.addr;
      ident_q <= COUNT_W'(cmd.addr) < ident_lim;
    end
  end

  assign rd_data = ident_q ? addr_q : mem_q;

endmodule

>>> src/dtws_divider.sv
// restoring divider, one quotient bit per cycle, splits a tile index into
// row and column; uses dtws_pkg
module dtws_divider import dtws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TILE_W-1:0] dividend,
  input  logic [DIM_W-1:0]  divisor,
  output logic              busy,
  output logic [TILE_W-1:0] quotient,
  output logic [DIM_W-1:0]  remainder
);

  logic [TILE_W-1:0]     quo;
  logic [DIM_W-1:0]      rem;
  logic [DIV_STEP_W-1:0] step;
  logic [DIM_W:0]        trial;
  logic [DIM_W:0]        diff;
  logic                  ge;

  assign trial = {rem, quo[TILE_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (step == DIV_STEP_W'(TILE_W - 1))) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      step <= '0;
    end else if (busy) begin
      quo  <= {quo[TILE_W-2:0], ge};
      rem  <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
      step <= step + 1'b1;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

>>> src/dirty_tile_work_stack.sv
// dirty tile work stack: control sequencer, config registers and result register
// instantiates dtws_bitmap, dtws_stack and dtws_divider; uses dtws_pkg
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | req_type, tile_index
//   out     | output    | out_valid / out_stall| taken_tile, taken_valid, pending_count
//   cfg     | input     | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// one transaction at a time; each bitmap mark is a lookup followed by an update
// out-of-range marks and empty takes go straight to the result; mark all fills all ROWS rows
// mark with neighbors overlaps the divider with the self mark, then walks the window
// position by position and marks each in-grid neighbor with its own lookup and update
// after reset a clearing pass over all ROWS bitmap rows holds in_stall high
// a finished result waits in the output register while the next item is accepted
module dirty_tile_work_stack import dtws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [TILE_W-1:0] tile_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TILE_W-1:0] taken_tile,
  output logic              taken_valid,
  output logic [COUNT_W-1:0] pending_count,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic       REG_COLS   = 1'b0;
  localparam logic       REG_ROWS   = 1'b1;
  localparam logic [3:0] NBR_CENTER = 4'd4;
  localparam logic [3:0] NBR_END    = 4'd9;
  localparam logic [1:0] OFF_NEG    = 2'd0;
  localparam logic [1:0] OFF_ZERO   = 2'd1;
  localparam logic [1:0] OFF_POS    = 2'd2;
  localparam int         CAND_W     = COUNT_W + 1;

  state_t             state;
  state_t             state_next;
  logic [DIM_W-1:0]   cfg_cols;
  logic [DIM_W-1:0]   cfg_rows;
  logic [2*DIM_W-1:0] grid_prod;
  logic [COUNT_W-1:0] tile_total;
  logic               in_accept;
  logic               idx_ok;
  logic [ROW_W-1:0]   row_cnt;
  logic [COUNT_W-1:0] top;
  logic [COUNT_W-1:0] top_dec;
  logic [TILE_W-1:0]  tile_q;
  logic [TILE_W-1:0]  cand;
  logic [3:0]         nbr_pos;
  logic               is_nbr;
  logic [TILE_W-1:0]  taken;
  logic               tvalid;
  logic               out_free;
  logic               push_ok;
  bmp_cmd_t           bmp_cmd;
  stk_cmd_t           stk_cmd;
  logic               bmp_pending;
  logic [TILE_W-1:0]  stk_rd_data;
  logic               div_start;
  logic               div_busy;
  logic [TILE_W-1:0]  tile_row;
  logic [DIM_W-1:0]   tile_col;
  logic [1:0]         nbr_dz;
  logic [1:0]         nbr_dx;
  logic               left_ok;
  logic               right_ok;
  logic               up_ok;
  logic               down_ok;
  logic               in_grid;
  logic [CAND_W-1:0]  nb_row;
  logic [CAND_W-1:0]  nb_cand;
  logic               nb_ok;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cols <= DIM_W'(1);
      cfg_rows <= DIM_W'(1);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_COLS: cfg_cols <= pwdata[DIM_W-1:0];
        default:  cfg_rows <= pwdata[DIM_W-1:0];
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_ROWS) ? 32'(cfg_rows) : 32'(cfg_cols);

  // tile count, saturated at the stack depth
  assign grid_prod  = (2*DIM_W)'(cfg_cols) * (2*DIM_W)'(cfg_rows);
  assign tile_total = (grid_prod > (2*DIM_W)'(MAX_TILES)) ? COUNT_W'(MAX_TILES)
                                                          : grid_prod[COUNT_W-1:0];

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign idx_ok    = COUNT_W'(tile_index) < tile_total;
  assign top_dec   = top - 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign push_ok   = !bmp_pending && (top < COUNT_W'(MAX_TILES));

  // neighbor walk: 3x3 window scanned row by row, center skipped
  always_comb begin
    case (nbr_pos) inside
      [4'd0:4'd2]: nbr_dz = OFF_NEG;
      [4'd3:4'd5]: nbr_dz = OFF_ZERO;
      default:     nbr_dz = OFF_POS;
    endcase
    case (nbr_pos) inside
      4'd0, 4'd3, 4'd6: nbr_dx = OFF_NEG;
      4'd1, 4'd4, 4'd7: nbr_dx = OFF_ZERO;
      default:          nbr_dx = OFF_POS;
    endcase
  end

  assign left_ok  = tile_col != '0;
  assign right_ok = ((DIM_W+1)'(tile_col) + 1'b1) < (DIM_W+1)'(cfg_cols);
  assign up_ok    = tile_row != '0;
  assign down_ok  = ((TILE_W+1)'(tile_row) + 1'b1) < (TILE_W+1)'(cfg_rows);
  assign in_grid  = !((nbr_dz == OFF_NEG) && !up_ok) && !((nbr_dz == OFF_POS) && !down_ok)
                 && !((nbr_dx == OFF_NEG) && !left_ok) && !((nbr_dx == OFF_POS) && !right_ok);

  always_comb begin
    case (nbr_dz)
      OFF_NEG:  nb_row = CAND_W'(tile_q) - CAND_W'(cfg_cols);
      OFF_ZERO: nb_row = CAND_W'(tile_q);
      default:  nb_row = CAND_W'(tile_q) + CAND_W'(cfg_cols);
    endcase
    case (nbr_dx)
      OFF_NEG:  nb_cand = nb_row - 1'b1;
      OFF_ZERO: nb_cand = nb_row;
      default:  nb_cand = nb_row + 1'b1;
    endcase
  end

  assign nb_ok = in_grid && (nbr_pos != NBR_CENTER) && (nb_cand < CAND_W'(tile_total));

  // sequencer
  always_comb begin
    state_next = state;
    bmp_cmd    = '0;
    stk_cmd    = '0;
    div_start  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        bmp_cmd.fill  = 1'b1;
        bmp_cmd.row   = row_cnt;
        bmp_cmd.count = '0;
        if (row_cnt == ROW_W'(ROWS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_accept) begin
          unique case (req_type)
            REQ_MARK_ONE: state_next = idx_ok ? S_MARK_RD : S_DONE;
            REQ_MARK_NBR: begin
              state_next = idx_ok ? S_MARK_RD : S_DONE;
              div_start  = idx_ok;
            end
            REQ_MARK_ALL: state_next = S_FILL;
            default: begin
              if (top != '0) begin
                stk_cmd.rd   = 1'b1;
                stk_cmd.addr = top_dec[TILE_W-1:0];
                state_next   = S_POP_LOOKUP;
              end else begin
                state_next = S_DONE;
              end
            end
          endcase
        end
      end
      S_MARK_RD: begin
        bmp_cmd.lookup = 1'b1;
        bmp_cmd.tile   = cand;
        state_next     = S_MARK_WR;
      end
      S_MARK_WR: begin
        if (push_ok) begin
          bmp_cmd.set   = 1'b1;
          stk_cmd.wr    = 1'b1;
          stk_cmd.addr  = top[TILE_W-1:0];
          stk_cmd.wdata = cand;
        end
        state_next = is_nbr ? S_NBR : S_DONE;
      end
      S_NBR: begin
        if (!div_busy) begin
          if (nbr_pos == NBR_END) begin
            state_next = S_DONE;
          end else if (nb_ok) begin
            state_next = S_MARK_RD;
          end
        end
      end
      S_FILL: begin
        bmp_cmd.fill  = 1'b1;
        bmp_cmd.row   = row_cnt;
        bmp_cmd.count = tile_total;
        if (row_cnt == ROW_W'(ROWS - 1)) begin
          stk_cmd.fill  = 1'b1;
          stk_cmd.count = tile_total;
          state_next    = S_DONE;
        end
      end
      S_POP_LOOKUP: begin
        bmp_cmd.lookup = 1'b1;
        bmp_cmd.tile   = stk_rd_data;
        state_next     = S_POP_CLEAR;
      end
      S_POP_CLEAR: begin
        bmp_cmd.clr = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      row_cnt   <= '0;
      top       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_CLEAR) || (state == S_FILL)) row_cnt <= row_cnt + 1'b1;
      if ((state == S_IDLE) && in_accept && (req_type == REQ_TAKE) && (top != '0)) begin
        top <= top_dec;
      end else if ((state == S_MARK_WR) && push_ok) begin
        top <= top + 1'b1;
      end else if ((state == S_FILL) && (row_cnt == ROW_W'(ROWS - 1))) begin
        top <= tile_total;
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_accept) begin
      tile_q  <= tile_index;
      cand    <= tile_index;
      is_nbr  <= (req_type == REQ_MARK_NBR);
      nbr_pos <= '0;
      taken   <= '0;
      tvalid  <= (req_type == REQ_TAKE) && (top != '0);
    end
    if ((state == S_NBR) && !div_busy && (nbr_pos != NBR_END)) begin
      nbr_pos <= nbr_pos + 1'b1;
      if (nb_ok) cand <= nb_cand[TILE_W-1:0];
    end
    if (state == S_POP_LOOKUP) taken <= stk_rd_data;
    if ((state == S_DONE) && out_free) begin
      taken_tile    <= taken;
      taken_valid   <= tvalid;
      pending_count <= top;
    end
  end

  dtws_bitmap u_bitmap (
    .clk     (clk),
    .cmd     (bmp_cmd),
    .pending (bmp_pending)
  );

  dtws_stack u_stack (
    .clk     (clk),
    .rst     (rst),
    .cmd     (stk_cmd),
    .rd_data (stk_rd_data)
  );

  dtws_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (tile_index),
    .divisor   (cfg_cols),
    .busy      (div_busy),
    .quotient  (tile_row),
    .remainder (tile_col)
  );

  // the stack never holds more entries than it has
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending_count <= COUNT_W'(MAX_TILES)))
    else $error("pending count above stack depth");

  // an empty or non-take transaction reports tile zero
  a_empty_take: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !taken_valid) |-> (taken_tile == '0))
    else $error("tile reported without a valid take");

  // the stack pointer only moves while a transaction is in work
  a_idle_top: assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE) && !in_accept) |=> $stable(top))
    else $error("stack top moved while idle");

endmodule

>>> verif/dirty_tile_work_stack_tb.sv
// self-checking testbench for dirty_tile_work_stack: directed and random requests
// checked against a bitmap-and-stack predictor; depends on dtws_pkg and the rtl only
module dirty_tile_work_stack_tb;
  import dtws_pkg::*;

  localparam int         CYCLE_LIMIT  = 1000000;
  localparam int         IDLE_PCT     = 9;
  localparam logic [2:0] ADDR_COLUMNS = 3'd0;
  localparam logic [2:0] ADDR_ROWS    = 3'd4;

  typedef struct packed {
    logic [TILE_W-1:0]  tile;
    logic               valid;
    logic [COUNT_W-1:0] count;
  } take_result_t;

  class tile_stack_scoreboard;
    bit                pending [MAX_TILES];
    logic [TILE_W-1:0] stack [MAX_TILES];
    int unsigned       depth;
    int unsigned       grid_cols;
    int unsigned       grid_rows;
    int                errors;
    take_result_t      expected_results [$];

    function void clear_all();
      foreach (pending[i]) pending[i] = 1'b0;
      depth = 0;
      grid_cols = 1;
      grid_rows = 1;
      errors = 0;
    endfunction

    function int unsigned tile_count();
      int unsigned n;
      n = grid_cols * grid_rows;
      return (n > MAX_TILES) ? MAX_TILES : n;
    endfunction

    function void push_tile(int unsigned idx);
      if (idx >= tile_count() || pending[idx] || depth >= MAX_TILES) return;
      pending[idx] = 1'b1;
      stack[depth] = idx[TILE_W-1:0];
      depth++;
    endfunction

    // self first, then the surrounding ring row by row, left to right
    function void push_with_neighbors(int unsigned idx);
      int col, row, cx, cz;
      if (idx >= tile_count()) return;
      push_tile(idx);
      col = idx % grid_cols;
      row = idx / grid_cols;
      for (int dz = -1; dz <= 1; dz++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          cx = col + dx;
          cz = row + dz;
          if ((dx != 0 || dz != 0) && cx >= 0 && cx < int'(grid_cols) &&
              cz >= 0 && cz < int'(grid_rows))
            push_tile(cx + cz * grid_cols);
        end
      end
    endfunction

    function void note_request(req_t req, logic [TILE_W-1:0] idx);
      take_result_t res;
      int unsigned  n;
      res = '0;
      case (req)
        REQ_MARK_ONE: push_tile(idx);
        REQ_MARK_NBR: push_with_neighbors(idx);
        REQ_MARK_ALL: begin
          n = tile_count();
          for (int i = 0; i < MAX_TILES; i++) begin
            pending[i] = (i < n);
            if (i < n) stack[i] = i[TILE_W-1:0];
          end
          depth = n;
        end
        default: begin
          if (depth > 0) begin
            depth--;
            res.tile = stack[depth];
            res.valid = 1'b1;
            pending[stack[depth]] = 1'b0;
          end
        end
      endcase
      res.count = depth[COUNT_W-1:0];
      expected_results = {expected_results, res};
    endfunction

    function void check_result(take_result_t got);
      take_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction tile=%0d valid=%0d count=%0d",
                 $time, got.tile, got.valid, got.count);
        return;
      end
      want = expected_results.pop_front();
      if (got.tile !== want.tile) begin
        errors++;
        $display("%0t: taken_tile expected %0d got %0d", $time, want.tile, got.tile);
      end
      if (got.valid !== want.valid) begin
        errors++;
        $display("%0t: taken_valid expected %0d got %0d", $time, want.valid, got.valid);
      end
      if (got.count !== want.count) begin
        errors++;
        $display("%0t: pending_count expected %0d got %0d", $time, want.count, got.count);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         req_type = '0;
  logic [TILE_W-1:0]  tile_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [TILE_W-1:0]  taken_tile;
  logic               taken_valid;
  logic [COUNT_W-1:0] pending_count;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  bit                   calm = 1'b0;
  int                   cycles = 0;
  tile_stack_scoreboard sb;

  dirty_tile_work_stack dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .tile_index(tile_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .taken_tile(taken_tile), .taken_valid(taken_valid), .pending_count(pending_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[dirty_tile_work_stack] ERROR");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{tile: taken_tile, valid: taken_valid, count: pending_count});
  end

  task automatic send_request(req_t req, logic [TILE_W-1:0] idx);
    int gap;
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    tile_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req, idx);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_access(bit wr, logic [2:0] addr, logic [31:0] data,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
  endtask

  // only called with the block idle and nothing pending
  task automatic set_grid(int cols, int rows);
    logic [31:0] rd;
    apb_access(1'b1, ADDR_COLUMNS, cols, rd);
    apb_access(1'b1, ADDR_ROWS, rows, rd);
    sb.grid_cols = cols;
    sb.grid_rows = rows;
    apb_access(1'b0, ADDR_COLUMNS, '0, rd);
    if (rd[DIM_W-1:0] !== cols[DIM_W-1:0]) begin
      sb.errors++;
      $display("%0t: tile_columns readback expected %0d got %0d", $time, cols, rd);
    end
    apb_access(1'b0, ADDR_ROWS, '0, rd);
    if (rd[DIM_W-1:0] !== rows[DIM_W-1:0]) begin
      sb.errors++;
      $display("%0t: tile_rows readback expected %0d got %0d", $time, rows, rd);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_requests(int n);
    int unsigned       pick, count;
    req_t              req;
    logic [TILE_W-1:0] idx;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 36)      req = REQ_MARK_ONE;
      else if (pick < 60) req = REQ_MARK_NBR;
      else if (pick < 96) req = REQ_TAKE;
      else                req = REQ_MARK_ALL;
      count = sb.tile_count();
      // mostly in-grid tiles, the rest any 12-bit index
      if (count > 0 && $urandom_range(0, 4) != 0) idx = TILE_W'($urandom_range(0, count - 1));
      else idx = TILE_W'($urandom());
      send_request(req, idx);
    end
  endtask

  initial begin
    int phase_cols [10];
    int phase_rows [10];
    sb = new();
    sb.clear_all();
    phase_cols = '{64, 127, 7, 1, 64, 0, 9, 2, 0, 0};
    phase_rows = '{64, 127, 3, 64, 1, 5, 13, 2, 0, 0};
    phase_cols[8] = $urandom_range(1, 127);
    phase_rows[8] = $urandom_range(1, 127);
    phase_cols[9] = $urandom_range(1, 127);
    phase_rows[9] = $urandom_range(1, 127);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset grid of one tile, empty stack
    send_request(REQ_TAKE, '0);
    send_request(REQ_MARK_ONE, '0);
    send_request(REQ_MARK_ONE, '0);
    send_request(REQ_MARK_NBR, '0);
    send_request(REQ_TAKE, '0);
    drain_results();

    set_grid(5, 4);
    send_request(REQ_MARK_ONE, 12'd19);
    send_request(REQ_MARK_ONE, 12'd20);
    send_request(REQ_MARK_ONE, 12'hFFF);
    send_request(REQ_MARK_NBR, 12'd0);
    send_request(REQ_MARK_NBR, 12'd12);
    send_request(REQ_MARK_NBR, 12'd19);
    send_request(REQ_MARK_NBR, 12'hFFF);
    repeat (3) send_request(REQ_TAKE, '0);
    send_request(REQ_MARK_ALL, 12'hABC);
    repeat (2) send_request(REQ_TAKE, 12'h555);
    send_request(REQ_MARK_ONE, 12'd19);
    drain_results();

    // zero columns: nothing can be marked and mark all empties the stack
    set_grid(0, 7);
    send_request(REQ_MARK_ONE, '0);
    send_request(REQ_MARK_NBR, '0);
    send_request(REQ_MARK_ALL, '0);
    send_request(REQ_TAKE, '0);
    drain_results();

    // saturated grid: neighbors past the tile count are dropped
    set_grid(127, 127);
    send_request(REQ_MARK_NBR, 12'hFFF);
    send_request(REQ_MARK_NBR, 12'd4000);
    send_request(REQ_TAKE, '0);
    drain_results();

    for (int p = 0; p < 10; p++) begin
      set_grid(phase_cols[p], phase_rows[p]);
      calm = (p == 2);
      random_requests((phase_cols[p] == 0) ? 20 : 180);
      drain_results();
    end
    calm = 1'b0;

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("[dirty_tile_work_stack] OK");
    else
      $display("[dirty_tile_work_stack] ERROR");
    $finish;
  end

endmodule

>>> dirty_tile_work_stack.f
src/dtws_pkg.sv
src/dtws_bitmap.sv
src/dtws_stack.sv
src/dtws_divider.sv
src/dirty_tile_work_stack.sv
verif/dirty_tile_work_stack_tb.sv
